### rtl/heartbeat_jam_mode_selector_assert.svh
// ----------------------------------------------------------------------------
// Heartbeat jam mode selector assertion macros
// Clocked, reset-qualified property wrappers shared by the RTL.
// ----------------------------------------------------------------------------
`ifndef HEARTBEAT_JAM_MODE_SELECTOR_ASSERT_SVH
`define HEARTBEAT_JAM_MODE_SELECTOR_ASSERT_SVH

// Same-cycle implication.
`define HJMS_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define HJMS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/hjms_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hjms_pkg
// Codes, field positions and types for the heartbeat jam mode selector.
// ----------------------------------------------------------------------------
package hjms_pkg;

   // request kinds (req_tuser)
   localparam logic CMD_OUTCOME = 1'b0;
   localparam logic CMD_TICK    = 1'b1;

   // policy codes
   localparam logic [1:0] POL_NORMAL  = 2'd0;
   localparam logic [1:0] POL_HOPPING = 2'd1;
   localparam logic [1:0] POL_JAM     = 2'd2;
   localparam logic [1:0] POL_KEEP    = 2'd3;

   // register indexes
   localparam logic [1:0] REG_ACTIVITY = 2'd0;
   localparam logic [1:0] REG_POLICY   = 2'd1;
   localparam logic [1:0] REG_WINDOW   = 2'd2;

   // counter slots
   localparam int CNT_OPP     = 0;
   localparam int CNT_VALID   = 1;
   localparam int CNT_MISSING = 2;
   localparam int CNT_ERRORED = 3;
   localparam int CNT_JAMMED  = 4;
   localparam int NUM_CNT     = 5;

   // fixed field widths
   localparam int TICK_BITS    = 16;
   localparam int WIN_OUT_BITS = 16;
   localparam int SES_OUT_BITS = 32;
   localparam int REQ_DATA_BITS = 8;
   localparam int RSP_DATA_BITS = 248;

   // request tdata bit positions
   localparam int REQ_DETECTED = 0;
   localparam int REQ_VALID    = 1;
   localparam int REQ_NOISY    = 2;
   localparam int REQ_WAVEFORM = 3;

   typedef logic [WIN_OUT_BITS-1:0] win_out_type;
   typedef logic [SES_OUT_BITS-1:0] ses_out_type;

endpackage

### rtl/heartbeat_jam_mode_selector.sv
`timescale 1ns / 1ps
// An accepted request's result is registered in the output register.
// Throughput: one request per cycle; the output register stalls the request side
// only while a result is held and rsp_tready is low.
// Reset (synchronous, active high): mode normal, counters and totals zero,
// activity on, jam-ratio policy, window of ten ticks, output register empty.
// ----------------------------------------------------------------------------
// heartbeat_jam_mode_selector
// Counts heartbeat outcomes per window and picks normal or hopping mode at
// each window end; keeps saturating session totals.
// ----------------------------------------------------------------------------
module heartbeat_jam_mode_selector #(
   parameter int WINDOW_COUNT_BITS  = 16,
   parameter int SESSION_COUNT_BITS = 32
) (
   input  logic                               clock,
   input  logic                               reset,
   // request channel
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // [0] frame_detected, [1] frame_valid, [2] end_noisy, [3] waveform_normal,
   // [7:4] zero
   input  logic [hjms_pkg::REQ_DATA_BITS-1:0] req_tdata,
   // [0] command
   input  logic                               req_tuser,
   // result channel
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // [0] normal_mode, [1] window_closed, [17:2] win_opportunities,
   // [33:18] win_valid, [49:34] win_missing, [65:50] win_errored,
   // [81:66] win_jammed, [113:82] total_opportunities, [145:114] total_valid,
   // [177:146] total_missing, [209:178] total_errored,
   // [241:210] total_jammed, [247:242] zero
   output logic [hjms_pkg::RSP_DATA_BITS-1:0] rsp_tdata,
   // configuration write channel
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [1:0]                         csr_index,
   input  logic [hjms_pkg::TICK_BITS-1:0]     csr_data
);
   import hjms_pkg::*;

   localparam int W        = WINDOW_COUNT_BITS;
   localparam int S        = SESSION_COUNT_BITS;
   localparam int SUM_BITS = ((S > W) ? S : W) + 1;
   localparam logic [W-1:0] WIN_MAX = {W{1'b1}};
   localparam logic [S-1:0] SES_MAX = {S{1'b1}};

   // configuration registers
   logic                 activity_ff;
   logic [1:0]           policy_ff;
   logic [TICK_BITS-1:0] window_ff;

   // block state
   logic                 mode_ff, mode_in;
   logic [TICK_BITS-1:0] tick_ff, tick_in;
   logic [W-1:0]         win_ff [NUM_CNT];
   logic [W-1:0]         win_in [NUM_CNT];
   logic [S-1:0]         ses_ff [NUM_CNT];
   logic [S-1:0]         ses_in [NUM_CNT];

   // output register
   logic                 rsp_valid_ff;
   logic                 rsp_mode_ff;
   logic                 rsp_closed_ff;
   logic [W-1:0]         rsp_win_ff [NUM_CNT];
   logic [S-1:0]         rsp_ses_ff [NUM_CNT];

   logic                 req_accept;
   logic                 csr_accept;
   logic                 is_tick;
   logic                 closing;
   logic                 decision;
   logic [TICK_BITS-1:0] tick_next;
   logic [NUM_CNT-1:0]   bump;
   logic [W+1:0]         load;
   logic [SUM_BITS-1:0]  sum [NUM_CNT];

   assign csr_ready  = 1'b1;
   assign csr_accept = csr_valid & csr_ready;

   // pipeline register: free or being emptied this cycle
   assign req_tready = ~rsp_valid_ff | rsp_tready;
   assign req_accept = req_tvalid & req_tready;

   assign is_tick   = (req_tuser == CMD_TICK);
   assign tick_next = tick_ff + TICK_BITS'(1);
   // a zero window behaves as one, since any count is >= 0
   assign closing   = is_tick & activity_ff & (tick_next >= window_ff);

   // outcome classification: opportunity always, then exactly one class
   always_comb begin
      bump = '0;
      if (!is_tick) begin
         bump[CNT_OPP] = 1'b1;
         if (!req_tdata[REQ_DETECTED] || !req_tdata[REQ_VALID]) begin
            if (req_tdata[REQ_NOISY]) begin
               bump[CNT_JAMMED] = 1'b1;
            end else if (!req_tdata[REQ_DETECTED]) begin
               bump[CNT_MISSING] = 1'b1;
            end else begin
               bump[CNT_ERRORED] = 1'b1;
            end
         end else begin
            bump[CNT_VALID] = 1'b1;
         end
      end
   end

   // jam-ratio load, wide enough that it never wraps
   assign load = ({2'b00, win_ff[CNT_JAMMED]} << 1) + {2'b00, win_ff[CNT_MISSING]}
               + {2'b00, win_ff[CNT_ERRORED]};

   always_comb begin
      case (policy_ff)
         POL_NORMAL:  decision = 1'b1;
         POL_HOPPING: decision = 1'b0;
         POL_JAM: begin
            if (win_ff[CNT_OPP] < W'(2)) begin
               decision = req_tdata[REQ_WAVEFORM];
            end else begin
               decision = (load <= {2'b00, win_ff[CNT_OPP]});
            end
         end
         default:     decision = req_tdata[REQ_WAVEFORM];
      endcase
   end

   // next state of counters and totals
   always_comb begin
      for (int k = 0; k < NUM_CNT; k++) begin
         sum[k] = SUM_BITS'(ses_ff[k]) + SUM_BITS'(win_ff[k]);
         if (closing) begin
            win_in[k] = '0;
            ses_in[k] = (sum[k][SUM_BITS-1:S] != '0) ? SES_MAX : sum[k][S-1:0];
         end else begin
            win_in[k] = (bump[k] && win_ff[k] != WIN_MAX) ? win_ff[k] + W'(1) : win_ff[k];
            ses_in[k] = ses_ff[k];
         end
      end
   end

   always_comb begin
      tick_in = tick_ff;
      if (is_tick && activity_ff) begin
         tick_in = closing ? '0 : tick_next;
      end
   end

   // a locked policy write forces the mode straight away
   always_comb begin
      mode_in = mode_ff;
      if (req_accept && closing) begin
         mode_in = decision;
      end
      if (csr_accept && csr_index == REG_POLICY) begin
         if (csr_data[1:0] == POL_NORMAL) begin
            mode_in = 1'b1;
         end else if (csr_data[1:0] == POL_HOPPING) begin
            mode_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         activity_ff <= 1'b1;
         policy_ff   <= POL_JAM;
         window_ff   <= TICK_BITS'(10);
         mode_ff     <= 1'b1;
         tick_ff     <= '0;
         for (int k = 0; k < NUM_CNT; k++) begin
            win_ff[k] <= '0;
            ses_ff[k] <= '0;
         end
      end else begin
         mode_ff <= mode_in;
         if (csr_accept) begin
            case (csr_index)
               REG_ACTIVITY: activity_ff <= csr_data[0];
               REG_POLICY:   policy_ff   <= csr_data[1:0];
               REG_WINDOW:   window_ff   <= csr_data;
               default:      ;
            endcase
         end
         if (req_accept) begin
            tick_ff <= tick_in;
            for (int k = 0; k < NUM_CNT; k++) begin
               win_ff[k] <= win_in[k];
               ses_ff[k] <= ses_in[k];
            end
         end
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_mode_ff   <= mode_in;
         rsp_closed_ff <= closing;
         for (int k = 0; k < NUM_CNT; k++) begin
            rsp_win_ff[k] <= win_in[k];
            rsp_ses_ff[k] <= ses_in[k];
         end
      end
   end

   // low bits of each count, zero-extended where the counter is narrower
   always_comb begin
      rsp_tdata    = '0;
      rsp_tdata[0] = rsp_mode_ff;
      rsp_tdata[1] = rsp_closed_ff;
      for (int k = 0; k < NUM_CNT; k++) begin
         rsp_tdata[2 + k*WIN_OUT_BITS +: WIN_OUT_BITS] = win_out_type'(64'(rsp_win_ff[k]));
         rsp_tdata[2 + NUM_CNT*WIN_OUT_BITS + k*SES_OUT_BITS +: SES_OUT_BITS] =
            ses_out_type'(64'(rsp_ses_ff[k]));
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

`include "heartbeat_jam_mode_selector_assert.svh"

   `HJMS_ASSERT_NOW(a_closed_clears_window, rsp_valid_ff && rsp_closed_ff, rsp_win_ff[CNT_OPP] == '0, "closed window result shows nonzero count")
   `HJMS_ASSERT_NEXT(a_close_restarts, req_accept && closing, tick_ff == '0 && win_ff[CNT_OPP] == '0, "window did not restart after close")
   `HJMS_ASSERT_NOW(a_classes_within_opp, 1'b1, win_ff[CNT_VALID] <= win_ff[CNT_OPP] && win_ff[CNT_MISSING] <= win_ff[CNT_OPP] && win_ff[CNT_ERRORED] <= win_ff[CNT_OPP] && win_ff[CNT_JAMMED] <= win_ff[CNT_OPP], "class count exceeds opportunities")
   `HJMS_ASSERT_NOW(a_locked_normal, policy_ff == POL_NORMAL, mode_ff == 1'b1, "locked normal policy but hopping mode")
   `HJMS_ASSERT_NOW(a_locked_hopping, policy_ff == POL_HOPPING, mode_ff == 1'b0, "locked hopping policy but normal mode")

endmodule

### test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the heartbeat jam mode selector. Heartbeat outcome
// and assess tick requests go in on the request stream. Every result is
// checked field by field against a cycle-free copy of the selector state or a
// directed table entry, with random idle bursts on both streams.
// ----------------------------------------------------------------------------
module tb_top;
   import hjms_pkg::*;

   // Index with no register behind it; writes to it must be ignored.
   localparam logic [1:0] REG_UNUSED = 2'd3;

   // Result word as it leaves rsp_tdata, lowest field last.
   typedef struct packed {
      logic [5:0]                       spare;
      ses_out_type [NUM_CNT-1:0]        total;
      win_out_type [NUM_CNT-1:0]        win;
      logic                             closed;
      logic                             mode;
   } mode_report_type;

   typedef enum logic { STEP_REQ, STEP_CSR } step_kind_type;

   // One row of the directed table.
   typedef struct {
      step_kind_type   kind;
      logic            cmd;
      logic [3:0]      bits;        // {waveform, noisy, valid, detected}
      logic [1:0]      index;
      logic [15:0]     data;
      bit              typed;       // check against exp rather than the predictor
      mode_report_type exp;
   } step_type;

   logic clock;
   logic reset = 1'b1;

   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic [REQ_DATA_BITS-1:0] req_tdata  = '0;
   logic                     req_tuser  = 1'b0;
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic [RSP_DATA_BITS-1:0] rsp_tdata;
   logic                     csr_valid  = 1'b0;
   logic                     csr_ready;
   logic [1:0]               csr_index  = '0;
   logic [TICK_BITS-1:0]     csr_data   = '0;

   // Predicted selector state and register copies.
   logic                      sel_mode;
   logic [TICK_BITS-1:0]      sel_ticks;
   win_out_type [NUM_CNT-1:0] win_cnt;
   ses_out_type [NUM_CNT-1:0] ses_cnt;
   logic                      cfg_activity;
   logic [1:0]                cfg_policy;
   logic [TICK_BITS-1:0]      cfg_window;

   mode_report_type awaited[$];    // results still owed by the block, oldest first
   step_type        directed[$];
   int              mismatches = 0;
   bit              idle_ok = 1'b1; // random idle bursts allowed on both streams

   heartbeat_jam_mode_selector dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // -------------------------------------------------------------------------
   // Predictor
   // -------------------------------------------------------------------------

   // Moves the predicted state on by one request and returns the result owed.
   function automatic mode_report_type advance_selector(logic cmd, logic [3:0] bits);
      mode_report_type      r;
      logic [TICK_BITS-1:0] next;
      logic [32:0]          sum;
      logic [18:0]          load;
      int                   slot;
      r = '0;
      if (cmd == CMD_OUTCOME) begin
         // lost or bad frames count as jammed when the end was noisy
         if (!bits[REQ_DETECTED])
            slot = bits[REQ_NOISY] ? CNT_JAMMED : CNT_MISSING;
         else if (!bits[REQ_VALID])
            slot = bits[REQ_NOISY] ? CNT_JAMMED : CNT_ERRORED;
         else
            slot = CNT_VALID;
         if (win_cnt[CNT_OPP] != '1) win_cnt[CNT_OPP] = win_cnt[CNT_OPP] + 16'd1;
         if (win_cnt[slot] != '1) win_cnt[slot] = win_cnt[slot] + 16'd1;
      end else if (cfg_activity) begin
         next = sel_ticks + 16'd1;
         if (next >= cfg_window) begin
            case (cfg_policy)
               POL_NORMAL:  sel_mode = 1'b1;
               POL_HOPPING: sel_mode = 1'b0;
               POL_JAM: begin
                  if (win_cnt[CNT_OPP] < 16'd2) begin
                     sel_mode = bits[REQ_WAVEFORM];
                  end else begin
                     // no wrap here: saturated, inconsistent counts pick hopping
                     load = 19'({win_cnt[CNT_JAMMED], 1'b0}) + 19'(win_cnt[CNT_MISSING])
                          + 19'(win_cnt[CNT_ERRORED]);
                     sel_mode = (load <= 19'(win_cnt[CNT_OPP]));
                  end
               end
               default:     sel_mode = bits[REQ_WAVEFORM];
            endcase
            for (int k = 0; k < NUM_CNT; k++) begin
               sum = {1'b0, ses_cnt[k]} + 33'(win_cnt[k]);
               ses_cnt[k] = sum[32] ? '1 : sum[31:0];
               win_cnt[k] = '0;
            end
            sel_ticks = '0;
            r.closed  = 1'b1;
         end else begin
            sel_ticks = next;
         end
      end
      r.mode  = sel_mode;
      r.win   = win_cnt;
      r.total = ses_cnt;
      return r;
   endfunction

   function automatic void apply_register(logic [1:0] index, logic [15:0] data);
      case (index)
         REG_ACTIVITY: cfg_activity = data[0];
         REG_POLICY: begin
            cfg_policy = data[1:0];
            // locked policies force the mode straight away
            if (data[1:0] == POL_NORMAL)
               sel_mode = 1'b1;
            else if (data[1:0] == POL_HOPPING)
               sel_mode = 1'b0;
         end
         REG_WINDOW:   cfg_window = data;
         default: ;
      endcase
   endfunction

   // -------------------------------------------------------------------------
   // Directed table
   // -------------------------------------------------------------------------

   function automatic mode_report_type typed_result(logic m, logic c, int o, int v, int ms,
                                                    int e, int j, int to, int tv, int tm,
                                                    int te, int tj);
      mode_report_type r;
      r = '0;
      r.mode   = m;
      r.closed = c;
      r.win[CNT_OPP]       = 16'(o);
      r.win[CNT_VALID]     = 16'(v);
      r.win[CNT_MISSING]   = 16'(ms);
      r.win[CNT_ERRORED]   = 16'(e);
      r.win[CNT_JAMMED]    = 16'(j);
      r.total[CNT_OPP]     = 32'(to);
      r.total[CNT_VALID]   = 32'(tv);
      r.total[CNT_MISSING] = 32'(tm);
      r.total[CNT_ERRORED] = 32'(te);
      r.total[CNT_JAMMED]  = 32'(tj);
      return r;
   endfunction

   function automatic void plan_req(logic cmd, logic [3:0] bits, bit typed,
                                    mode_report_type exp);
      directed.push_back('{STEP_REQ, cmd, bits, REG_ACTIVITY, 16'd0, typed, exp});
   endfunction

   function automatic void plan_csr(logic [1:0] index, logic [15:0] data);
      directed.push_back('{STEP_CSR, CMD_OUTCOME, 4'd0, index, data, 1'b0, '0});
   endfunction

   // -------------------------------------------------------------------------
   // Drivers
   // -------------------------------------------------------------------------

   // Presents one request and waits for it to be taken. tvalid is left high;
   // the caller either follows with another request in the same step or
   // lowers it.
   task automatic send_request(input logic cmd, input logic [3:0] bits, input bit typed,
                               input mode_report_type typed_exp);
      mode_report_type predicted;
      if (idle_ok && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {4'b0000, bits};
      do @(posedge clock); while (!req_tready);
      predicted = advance_selector(cmd, bits);
      awaited.push_back(typed ? typed_exp : predicted);
   endtask

   task automatic write_reg(input logic [1:0] index, input logic [15:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      apply_register(index, data);
   endtask

   // Stop sending, wait for every owed result, then let the pipeline run dry.
   task automatic settle();
      req_tvalid <= 1'b0;
      csr_valid  <= 1'b0;
      while (awaited.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   // Full register set between phases; high data bits are junk the block
   // must mask off.
   task automatic program_selector(input logic act, input logic [1:0] pol,
                                   input logic [15:0] win);
      settle();
      write_reg(REG_ACTIVITY, {15'($urandom), act});
      write_reg(REG_POLICY, {14'($urandom), pol});
      write_reg(REG_WINDOW, win);
      if ($urandom_range(0, 2) == 0) write_reg(REG_UNUSED, 16'($urandom));
      csr_valid <= 1'b0;
   endtask

   // -------------------------------------------------------------------------
   // Result side: random back-pressure and checking
   // -------------------------------------------------------------------------
   always @(posedge clock) begin : rsp_side
      mode_report_type got;
      mode_report_type want;
      bit              bad;
      int              stall_left;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         if (awaited.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result %h", got);
         end else begin
            want = awaited.pop_front();
            bad = (got.mode != want.mode) || (got.closed != want.closed);
            for (int k = 0; k < NUM_CNT; k++)
               bad = bad || (got.win[k] != want.win[k]) || (got.total[k] != want.total[k]);
            if (bad) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: mode %0d/%0d closed %0d/%0d win %h/%h totals %h/%h",
                           want.mode, got.mode, want.closed, got.closed,
                           want.win, got.win, want.total, got.total);
            end
         end
      end
      // random stall bursts
      if (stall_left != 0) begin
         rsp_tready <= 1'b0;
         stall_left--;
      end else if (idle_ok && $urandom_range(0, 7) == 0) begin
         rsp_tready <= 1'b0;
         stall_left = $urandom_range(0, 8);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // -------------------------------------------------------------------------
   // Stimulus
   // -------------------------------------------------------------------------
   initial begin : stimulus
      logic        act;
      logic [1:0]  pol;
      logic [15:0] win;
      int          bias, tick_pct, count;

      // predictor starts from the reset state
      cfg_activity = 1'b1;
      cfg_policy   = POL_JAM;
      cfg_window   = 16'd10;
      sel_mode     = 1'b1;
      sel_ticks    = '0;
      win_cnt      = '0;
      ses_cnt      = '0;

      // Directed part, reset settings first (ratio policy, window of ten).
      // Bits are {waveform, noisy, valid, detected}.
      plan_req(CMD_OUTCOME, 4'b0000, 1, typed_result(1, 0, 1, 0, 1, 0, 0, 0, 0, 0, 0, 0));
      // lost and noisy; valid bit means nothing without detection
      plan_req(CMD_OUTCOME, 4'b0110, 1, typed_result(1, 0, 2, 0, 1, 0, 1, 0, 0, 0, 0, 0));
      plan_req(CMD_OUTCOME, 4'b0001, 1, typed_result(1, 0, 3, 0, 1, 1, 1, 0, 0, 0, 0, 0));
      plan_req(CMD_OUTCOME, 4'b0101, 1, typed_result(1, 0, 4, 0, 1, 1, 2, 0, 0, 0, 0, 0));
      plan_req(CMD_OUTCOME, 4'b0111, 1, typed_result(1, 0, 5, 1, 1, 1, 2, 0, 0, 0, 0, 0));
      plan_req(CMD_OUTCOME, 4'b1011, 1, typed_result(1, 0, 6, 2, 1, 1, 2, 0, 0, 0, 0, 0));
      // two ticks, outcome fields ignored
      plan_req(CMD_TICK, 4'b0111, 1, typed_result(1, 0, 6, 2, 1, 1, 2, 0, 0, 0, 0, 0));
      plan_req(CMD_TICK, 4'b1000, 1, typed_result(1, 0, 6, 2, 1, 1, 2, 0, 0, 0, 0, 0));
      // window cut below the tick count: next tick closes; load equals
      // opportunities, so normal despite a hopping waveform
      plan_csr(REG_WINDOW, 16'd1);
      plan_req(CMD_TICK, 4'b0000, 1, typed_result(1, 1, 0, 0, 0, 0, 0, 6, 2, 1, 1, 2));
      // zero window behaves as one
      plan_csr(REG_WINDOW, 16'd0);
      plan_req(CMD_OUTCOME, 4'b0100, 0, '0);
      plan_req(CMD_TICK, 4'b0000, 0, '0);     // under two opportunities: copy waveform
      plan_req(CMD_OUTCOME, 4'b0100, 0, '0);
      plan_req(CMD_OUTCOME, 4'b0000, 0, '0);
      plan_req(CMD_TICK, 4'b1000, 0, '0);     // overloaded: hopping
      plan_csr(REG_POLICY, {14'h3FFF, POL_NORMAL});
      plan_req(CMD_OUTCOME, 4'b0011, 0, '0);  // mode already forced
      plan_req(CMD_TICK, 4'b0000, 0, '0);
      plan_csr(REG_POLICY, {14'h0000, POL_HOPPING});
      plan_req(CMD_OUTCOME, 4'b0011, 0, '0);
      plan_req(CMD_TICK, 4'b1000, 0, '0);
      plan_csr(REG_POLICY, {14'h1555, POL_KEEP});
      plan_req(CMD_TICK, 4'b1000, 0, '0);
      plan_req(CMD_TICK, 4'b0000, 0, '0);
      // activity off: ticks do nothing, outcomes still count
      plan_csr(REG_ACTIVITY, 16'hFFFE);
      plan_req(CMD_TICK, 4'b1111, 0, '0);
      plan_req(CMD_OUTCOME, 4'b0001, 0, '0);
      plan_csr(REG_UNUSED, 16'hFFFF);
      plan_csr(REG_ACTIVITY, 16'h0001);
      plan_req(CMD_TICK, 4'b1000, 0, '0);

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      foreach (directed[i]) begin
         if (directed[i].kind == STEP_CSR) begin
            settle();
            write_reg(directed[i].index, directed[i].data);
         end else begin
            csr_valid <= 1'b0;
            send_request(directed[i].cmd, directed[i].bits, directed[i].typed,
                         directed[i].exp);
         end
      end

      // Random phases. The widest window in phase 1 leaves a large tick count
      // for phase 2 to cut short; the last phase runs without idling.
      for (int phase = 0; phase < 12; phase++) begin
         case (phase)
            1:       win = 16'hFFFF;
            3:       win = 16'd0;
            4:       win = 16'd1;
            5:       win = 16'd10;
            default: win = 16'($urandom_range(1, 16));
         endcase
         act = (phase == 6) ? 1'b0 : ($urandom_range(0, 7) != 0);
         pol = (phase < 4) ? 2'(phase) : 2'($urandom_range(0, 3));
         idle_ok = (phase != 11);
         program_selector(act, pol, win);
         bias     = $urandom_range(0, 100);
         tick_pct = $urandom_range(10, 50);
         count    = $urandom_range(60, 95);
         repeat (count) begin
            if ($urandom_range(0, 99) < tick_pct)
               send_request(CMD_TICK, 4'($urandom), 0, '0);
            else if ($urandom_range(0, 99) < bias)
               send_request(CMD_OUTCOME, {2'($urandom), 2'b11}, 0, '0);
            else
               send_request(CMD_OUTCOME, 4'($urandom), 0, '0);
         end
      end

      settle();
      if (mismatches == 0 && awaited.size() == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

   // Hang guard, several times the slowest legal run.
   initial begin
      #1ms;
      $display("== FAIL ==");
      $finish;
   end

endmodule

### heartbeat_jam_mode_selector.f
+incdir+rtl
rtl/hjms_pkg.sv
rtl/heartbeat_jam_mode_selector.sv
test/tb_top.sv
